>>> rtl/mau_pkg.sv
package mau_pkg;

  // Data path width of operands, modulus and result
  localparam int WIDTH = 32;

  // Bit counter width for one shift-add pass over WIDTH bits
  localparam int CNT_W = $clog2(WIDTH);

  // Operation codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_POW = 3'd3;
  localparam logic [2:0] OP_INV = 3'd4;
  localparam logic [2:0] OP_DIV = 3'd5;

endpackage

>>> rtl/modular_arithmetic_unit.sv
// Add and subtract reduce both operands, then add or subtract; multiply reduces and
// multiplies; power and inverse square and multiply over every exponent bit, and
// divide ends with one more multiply; modulus 0 or 1 or an unused code gives zero.
// One word at a time: a new word is taken in the cycle the result strobes.
// The shared shift-add modular step unit works one bit per cycle.
// Synchronous active-low reset returns to idle and sets the modulus to 1.
module modular_arithmetic_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_operation,
  input  logic [mau_pkg::WIDTH-1:0]   in_operand_a,
  input  logic [mau_pkg::WIDTH-1:0]   in_operand_b,
  output logic                        out_valid,
  output logic [mau_pkg::WIDTH-1:0]   out_result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mau_pkg::WIDTH-1:0]   cfg_modulus
);
  import mau_pkg::*;

  localparam int W = WIDTH;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_RED_A   = 7'b0000010,
    S_RED_B   = 7'b0000100,
    S_POW_SQ  = 7'b0001000,
    S_POW_MUL = 7'b0010000,
    S_MUL_FIN = 7'b0100000,
    S_ALU     = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [W-1:0]     modulus_r;
  logic [2:0]       op_r, op_nxt;
  logic             zero_r, zero_nxt;
  logic [W-1:0]     a_r, a_nxt;
  logic [W-1:0]     b_r, b_nxt;
  logic [W-1:0]     e_r, e_nxt;
  logic [W-1:0]     base_r, base_nxt;
  logic [W-1:0]     mx_r, mx_nxt;
  logic [W-1:0]     my_r, my_nxt;
  logic [W-1:0]     macc_r, macc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rnd_r, rnd_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [W-1:0]     out_result_r, out_result_nxt;

  // Load requests for the shared step unit
  logic             ld_mul;
  logic [W-1:0]     ld_x, ld_y;
  logic             round_end;

  // Shared step unit: acc = 2*acc + bit*x mod m
  logic [W+1:0] m_ext, st_sum, st_sub1, st_sub2;
  logic [W-1:0] st_res;
  logic         st_last;

  assign m_ext   = {2'b00, modulus_r};
  assign st_sum  = {1'b0, macc_r, 1'b0} + (my_r[W-1] ? {2'b00, mx_r} : {(W+2){1'b0}});
  assign st_sub1 = st_sum - m_ext;
  assign st_sub2 = st_sum - {m_ext[W:0], 1'b0};
  assign st_last = (cnt_r == {CNT_W{1'b0}});

  always_comb begin
    if (!st_sub2[W+1]) begin
      st_res = st_sub2[W-1:0];
    end else if (!st_sub1[W+1]) begin
      st_res = st_sub1[W-1:0];
    end else begin
      st_res = st_sum[W-1:0];
    end
  end

  // Add and subtract on reduced operands
  logic [W:0]   add_sum, add_red, sub_dif, sub_fix;
  logic [W-1:0] alu_res;

  assign add_sum = {1'b0, a_r} + {1'b0, b_r};
  assign add_red = add_sum - {1'b0, modulus_r};
  assign sub_dif = {1'b0, a_r} - {1'b0, b_r};
  assign sub_fix = sub_dif + {1'b0, modulus_r};

  always_comb begin
    if (zero_r) begin
      alu_res = {W{1'b0}};
    end else if (op_r == OP_ADD) begin
      alu_res = add_red[W] ? add_sum[W-1:0] : add_red[W-1:0];
    end else begin
      alu_res = sub_dif[W] ? sub_fix[W-1:0] : sub_dif[W-1:0];
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    zero_nxt       = zero_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    e_nxt          = e_r;
    base_nxt       = base_r;
    mx_nxt         = mx_r;
    my_nxt         = my_r;
    macc_nxt       = macc_r;
    cnt_nxt        = cnt_r;
    rnd_nxt        = rnd_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    ld_mul         = 1'b0;
    ld_x           = {W{1'b0}};
    ld_y           = {W{1'b0}};
    round_end      = 1'b0;

    // Advance the step unit in every multiply state
    if (state_r != S_IDLE && state_r != S_ALU) begin
      macc_nxt = st_res;
      my_nxt   = {my_r[W-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_operation;
          e_nxt  = in_operand_b;
          b_nxt  = in_operand_b;
          if (modulus_r <= {{(W-1){1'b0}}, 1'b1} || in_operation > OP_DIV) begin
            zero_nxt  = 1'b1;
            state_nxt = S_ALU;
          end else begin
            zero_nxt  = 1'b0;
            ld_mul    = 1'b1;
            ld_x      = {{(W-1){1'b0}}, 1'b1};
            ld_y      = in_operand_a;
            state_nxt = S_RED_A;
          end
        end
      end
      S_RED_A: begin
        if (st_last) begin
          a_nxt     = st_res;
          ld_mul    = 1'b1;
          ld_x      = {{(W-1){1'b0}}, 1'b1};
          ld_y      = b_r;
          state_nxt = S_RED_B;
        end
      end
      S_RED_B: begin
        if (st_last) begin
          b_nxt   = st_res;
          rnd_nxt = CNT_LAST;
          if (op_r == OP_ADD || op_r == OP_SUB) begin
            state_nxt = S_ALU;
          end else if (op_r == OP_MUL) begin
            ld_mul    = 1'b1;
            ld_x      = a_r;
            ld_y      = st_res;
            state_nxt = S_MUL_FIN;
          end else begin
            // Power family: start from 1 and square first
            base_nxt = (op_r == OP_DIV) ? st_res : a_r;
            if (op_r != OP_POW) begin
              e_nxt = modulus_r - {{(W-2){1'b0}}, 2'd2};
            end
            ld_mul    = 1'b1;
            ld_x      = {{(W-1){1'b0}}, 1'b1};
            ld_y      = {{(W-1){1'b0}}, 1'b1};
            state_nxt = S_POW_SQ;
          end
        end
      end
      S_POW_SQ: begin
        if (st_last) begin
          if (e_r[W-1]) begin
            ld_mul    = 1'b1;
            ld_x      = base_r;
            ld_y      = st_res;
            state_nxt = S_POW_MUL;
          end else begin
            round_end = 1'b1;
          end
        end
      end
      S_POW_MUL: begin
        if (st_last) begin
          round_end = 1'b1;
        end
      end
      S_MUL_FIN: begin
        if (st_last) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = st_res;
          state_nxt      = S_IDLE;
        end
      end
      S_ALU: begin
        out_valid_nxt  = 1'b1;
        out_result_nxt = alu_res;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Close one exponent bit: next square, final multiply or done
    if (round_end) begin
      e_nxt = {e_r[W-2:0], 1'b0};
      if (rnd_r == {CNT_W{1'b0}}) begin
        if (op_r == OP_DIV) begin
          ld_mul    = 1'b1;
          ld_x      = a_r;
          ld_y      = st_res;
          state_nxt = S_MUL_FIN;
        end else begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = st_res;
          state_nxt      = S_IDLE;
        end
      end else begin
        rnd_nxt   = rnd_r - 1'b1;
        ld_mul    = 1'b1;
        ld_x      = st_res;
        ld_y      = st_res;
        state_nxt = S_POW_SQ;
      end
    end

    // Load a new multiply pass
    if (ld_mul) begin
      mx_nxt   = ld_x;
      my_nxt   = ld_y;
      macc_nxt = {W{1'b0}};
      cnt_nxt  = CNT_LAST;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= {{(W-1){1'b0}}, 1'b1};
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        modulus_r <= cfg_modulus;
      end
    end
  end

  // Data path registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    zero_r       <= zero_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    e_r          <= e_nxt;
    base_r       <= base_nxt;
    mx_r         <= mx_nxt;
    my_r         <= my_nxt;
    macc_r       <= macc_nxt;
    cnt_r        <= cnt_nxt;
    rnd_r        <= rnd_nxt;
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // Result always lies below the modulus, or is zero for a trivial modulus
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((modulus_r <= {{(W-1){1'b0}}, 1'b1}) ?
                     (out_result_r == {W{1'b0}}) : (out_result_r < modulus_r)))
    else $error("result out of range");

  // A result strobe follows a busy cycle
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy))
    else $error("result without work");

  // Strobe lasts one cycle per word
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("strobe repeated");

  // An accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accept did not start work");

  // Modulus holds while a word is at work
  a_mod_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy)) |-> $stable(modulus_r))
    else $error("modulus changed during work");

endmodule

>>> tb/modular_arithmetic_checker.sv
module modular_arithmetic_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [2:0]                in_operation,
  input  logic [mau_pkg::WIDTH-1:0] in_operand_a,
  input  logic [mau_pkg::WIDTH-1:0] in_operand_b,
  input  logic                      out_valid,
  input  logic [mau_pkg::WIDTH-1:0] out_result,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [mau_pkg::WIDTH-1:0] cfg_modulus,
  output int                        error_count,
  output int                        pending_count,
  output int                        compared_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import mau_pkg::*;

  typedef struct packed {
    logic [2:0]       op;
    logic [WIDTH-1:0] value;
  } residue_word_t;

  residue_word_t    expected_residues[$];
  logic [WIDTH-1:0] modulus_q = 1;
  int               mismatches = 0;
  int               compared = 0;

  // Exact product reduced by the modulus, formed at double width
  function automatic logic [WIDTH-1:0] mulmod(input logic [WIDTH-1:0] x,
                                              input logic [WIDTH-1:0] y,
                                              input logic [WIDTH-1:0] m);
    logic [2*WIDTH-1:0] prod;
    prod = {{WIDTH{1'b0}}, x} * {{WIDTH{1'b0}}, y};
    prod = prod % {{WIDTH{1'b0}}, m};
    return prod[WIDTH-1:0];
  endfunction

  // Square and multiply over every exponent bit, top bit first
  function automatic logic [WIDTH-1:0] powmod(input logic [WIDTH-1:0] base,
                                              input logic [WIDTH-1:0] expo,
                                              input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] acc;
    acc = (m == 1) ? '0 : 1;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      acc = mulmod(acc, acc, m);
      if (expo[i]) begin
        acc = mulmod(acc, base, m);
      end
    end
    return acc;
  endfunction

  // Residue that one command word must produce under modulus m
  function automatic logic [WIDTH-1:0] modular_result(input logic [2:0]       op,
                                                      input logic [WIDTH-1:0] a,
                                                      input logic [WIDTH-1:0] b,
                                                      input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] ar;
    logic [WIDTH-1:0] br;
    logic [WIDTH-1:0] fermat;
    logic [WIDTH:0]   sum;
    if (m == 0) begin
      return '0;
    end
    ar = a % m;
    br = b % m;
    fermat = (m >= 2) ? m - 2 : '0;
    case (op)
      OP_ADD: begin
        sum = {1'b0, ar} + {1'b0, br};
        if (sum >= {1'b0, m}) begin
          sum = sum - {1'b0, m};
        end
        return sum[WIDTH-1:0];
      end
      OP_SUB: begin
        return (ar >= br) ? ar - br : m - (br - ar);
      end
      OP_MUL: return mulmod(ar, br, m);
      OP_POW: return powmod(ar, b, m);
      OP_INV: return powmod(ar, fermat, m);
      OP_DIV: return mulmod(ar, powmod(br, fermat, m), m);
      default: return '0;
    endcase
  endfunction

  always @(posedge clk) begin
    residue_word_t want;
    if (!rst_n) begin
      modulus_q = 1;
      expected_residues.delete();
    end else begin
      // Predict each accepted command word under the current modulus
      if (start && !busy) begin
        want.op = in_operation;
        want.value = modular_result(in_operation, in_operand_a, in_operand_b, modulus_q);
        expected_residues = {expected_residues, want};
      end
      // Match each strobed result against the oldest prediction
      if (out_valid) begin
        if (expected_residues.size() == 0) begin
          mismatches++;
          $error("unexpected result word: result expected none, actual 0x%08h",
                 out_result);
        end else begin
          want = expected_residues.pop_front();
          compared++;
          if (out_result !== want.value) begin
            mismatches++;
            $error("op %0d field result: expected 0x%08h, actual 0x%08h",
                   want.op, want.value, out_result);
          end
        end
      end
      // Track modulus writes
      if (cfg_valid && cfg_ready) begin
        modulus_q = cfg_modulus;
      end
    end
    error_count <= mismatches;
    compared_count <= compared;
    pending_count <= expected_residues.size();
  end

endmodule

>>> tb/modular_arithmetic_unit_tb.sv
module modular_arithmetic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mau_pkg::*;

  localparam logic [2:0]       OP_SPARE_LO = 3'd6;
  localparam logic [2:0]       OP_SPARE_HI = 3'd7;
  localparam logic [WIDTH-1:0] TOP_PRIME = 32'd4294967291;
  localparam logic [WIDTH-1:0] ALL_ONES = '1;
  localparam int               STALL_LIMIT = 10000;
  localparam int               NUM_PHASES = 10;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [2:0]       in_operation;
  logic [WIDTH-1:0] in_operand_a;
  logic [WIDTH-1:0] in_operand_b;
  logic             out_valid;
  logic [WIDTH-1:0] out_result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [WIDTH-1:0] cfg_modulus;

  int               error_count;
  int               pending_count;
  int               compared_count;
  int               stall_cycles = 0;
  int               words_sent = 0;
  int               slow_words = 0;
  bit               quiet = 1'b0;
  logic [WIDTH-1:0] modulus_now = 1;

  logic [WIDTH-1:0] phase_modulus[NUM_PHASES] =
    '{32'd1, TOP_PRIME, 32'd2, 32'd3, 32'd65521, ALL_ONES, 32'd1000000007,
      32'd0, 32'd0, 32'd1};
  int               phase_words[NUM_PHASES] = '{10, 60, 25, 25, 35, 35, 35, 25, 10, 10};

  modular_arithmetic_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_result   (out_result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_modulus  (cfg_modulus)
  );

  modular_arithmetic_checker scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .out_valid      (out_valid),
    .out_result     (out_result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_modulus    (cfg_modulus),
    .error_count    (error_count),
    .pending_count  (pending_count),
    .compared_count (compared_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // End the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one command word, idling at random first unless quiet, and hold until taken
  task automatic send_word(input logic [2:0] op, input logic [WIDTH-1:0] a,
                           input logic [WIDTH-1:0] b);
    while (!quiet && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (busy);
    words_sent++;
    if (op == OP_POW || op == OP_INV || op == OP_DIV) begin
      slow_words++;
    end
  endtask

  // Drop start and wait until every predicted word has come back
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic write_modulus(input logic [WIDTH-1:0] value);
    cfg_valid <= 1'b1;
    cfg_modulus <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    modulus_now = value;
  endtask

  // Operand mix: extremes, values around the modulus, small and full random
  function automatic logic [WIDTH-1:0] pick_operand(input logic [WIDTH-1:0] m);
    case ($urandom_range(9))
      0: return '0;
      1: return ALL_ONES;
      2: return m - 1;
      3: return m;
      4: return m + 1;
      5: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WIDTH-1:0] pick_exponent();
    case ($urandom_range(5))
      0: return '0;
      1: return 1;
      2: return $urandom_range(31);
      3: return ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_operation();
    int r;
    r = $urandom_range(99);
    if (r < 18) return OP_ADD;
    if (r < 36) return OP_SUB;
    if (r < 56) return OP_MUL;
    if (r < 72) return OP_POW;
    if (r < 82) return OP_INV;
    if (r < 96) return OP_DIV;
    if (r < 98) return OP_SPARE_LO;
    return OP_SPARE_HI;
  endfunction

  initial begin
    logic [2:0] op;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_operation <= OP_ADD;
    in_operand_a <= '0;
    in_operand_b <= '0;
    cfg_valid <= 1'b0;
    cfg_modulus <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Change the modulus only once the unit has gone idle
      if (ph > 0) begin
        drain();
        write_modulus((ph == 7) ? ($urandom | 32'h8000_0001) : phase_modulus[ph]);
      end
      quiet = (ph == 3);

      // Directed corners for this modulus
      case (ph)
        0: begin
          send_word(OP_ADD, ALL_ONES, ALL_ONES);
          send_word(OP_POW, 5, 0);
          send_word(OP_INV, 7, 0);
        end
        1: begin
          send_word(OP_ADD, ALL_ONES, ALL_ONES);
          send_word(OP_SUB, 0, ALL_ONES);
          send_word(OP_SUB, ALL_ONES, 0);
          send_word(OP_MUL, ALL_ONES, ALL_ONES);
          send_word(OP_MUL, 0, 12345);
          send_word(OP_POW, 9, 0);
          send_word(OP_POW, 0, 0);
          send_word(OP_POW, ALL_ONES, ALL_ONES);
          send_word(OP_INV, 0, 0);
          send_word(OP_INV, ALL_ONES, 0);
          send_word(OP_INV, 1, ALL_ONES);
          send_word(OP_DIV, 1234567, 0);
          send_word(OP_DIV, ALL_ONES, ALL_ONES);
          send_word(OP_SPARE_LO, ALL_ONES, ALL_ONES);
          send_word(OP_SPARE_HI, 3, 4);
        end
        2: begin
          send_word(OP_INV, 3, 0);
          send_word(OP_INV, 0, 0);
          send_word(OP_DIV, ALL_ONES, 0);
        end
        8: begin
          send_word(OP_ADD, 5, 6);
          send_word(OP_POW, 3, 4);
          send_word(OP_DIV, ALL_ONES, ALL_ONES);
        end
        default: ;
      endcase

      // Random words under this modulus
      for (int n = 0; n < phase_words[ph]; n++) begin
        if (ph == 4 && n == 15) begin
          drain();
        end
        op = pick_operation();
        send_word(op, pick_operand(modulus_now),
                  (op == OP_POW) ? pick_exponent() : pick_operand(modulus_now));
      end
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Sent %0d command words over %0d modulus settings, %0d of them power,",
             words_sent, NUM_PHASES, slow_words);
    $display("inverse or divide; %0d results compared, %0d mismatches.",
             compared_count, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
